### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for clocked concurrent assertions with an active-low reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Whenever the antecedent holds, the consequent holds in the same cycle.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

### sv/lkv_pkg.sv
// ----------------------------------------------------------------------------
// lkv_pkg
// Types and constants shared by the key-value cache modules.
// ----------------------------------------------------------------------------
package lkv_pkg;

    localparam int KEY_W = 16;
    localparam int VAL_W = 32;
    localparam int CAP_W = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    typedef struct packed {
        logic             opcode;
        logic [KEY_W-1:0] lookup_key;
        logic [VAL_W-1:0] store_value;
    } req_word_t;

    typedef struct packed {
        logic             hit;
        logic [VAL_W-1:0] read_value;
    } rsp_word_t;

    // Write enables of the entry memories.
    typedef struct packed {
        logic kv;
        logic rank;
    } ram_we_t;

    // Flags from the shared compare unit.
    typedef struct packed {
        logic key_eq;
        logic rank_gt;
        logic rank_lt;
    } cmp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_AGE,
        ST_COMMIT
    } lkv_state_t;

endpackage

### sv/lru_key_value_cache.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache
// Fully associative key-value cache with least-recently-used replacement.
// ----------------------------------------------------------------------------
// Usage:
//   Request words (opcode, lookup_key, store_value) arrive on req_valid and
//   are taken when req_stall is low; req_stall is high while an item is being
//   worked on. Each request gives exactly one response word (hit, read_value)
//   on rsp_valid, held in an output register until rsp_stall is low.
//   A sequencer walks the entries one per cycle through a single memory read
//   port and one shared compare unit. After the search pass the response is
//   registered, and a get that misses is finished. Hits and puts run a second
//   pass to age the recency ranks and then a commit state that writes the slot.
//   When the receiver stalls, the block still takes the next request; it only
//   waits before loading a new response while the previous one is unread.
//   The capacity register (cfg_we, cfg_wdata) must be written only while idle; the block does not enforce this.
//   Reset empties the cache and sets capacity to 16; no clearing pass.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lru_key_value_cache #(
    parameter int ENTRIES = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      req_valid,
    output logic                      req_stall,
    input  lkv_pkg::req_word_t        req_word,
    output logic                      rsp_valid,
    input  logic                      rsp_stall,
    output lkv_pkg::rsp_word_t        rsp_word,
    input  logic                      cfg_we,
    input  logic [lkv_pkg::CAP_W-1:0] cfg_wdata
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int EW = (CW > lkv_pkg::CAP_W) ? CW : lkv_pkg::CAP_W;
    localparam logic [CW-1:0] LAST = CW'(ENTRIES);

    lkv_pkg::lkv_state_t state_reg, state_next;

    logic [lkv_pkg::CAP_W-1:0] cap_reg, cap_next;
    logic [ENTRIES-1:0]        valid_reg, valid_next;
    logic [CW-1:0]             used_reg, used_next;

    logic                      op_reg, op_next;
    logic [lkv_pkg::KEY_W-1:0] key_reg, key_next;
    logic [lkv_pkg::VAL_W-1:0] val_reg, val_next;

    logic [CW-1:0]             cnt_reg, cnt_next;
    logic                      rd_vld_reg, rd_vld_next;
    logic [IW-1:0]             rd_idx_reg, rd_idx_next;

    logic                      found_reg, found_next;
    logic [IW-1:0]             found_idx_reg, found_idx_next;
    logic [IW-1:0]             found_rank_reg, found_rank_next;
    logic [lkv_pkg::VAL_W-1:0] found_val_reg, found_val_next;
    logic                      best_vld_reg, best_vld_next;
    logic [IW-1:0]             best_idx_reg, best_idx_next;
    logic [IW-1:0]             best_rank_reg, best_rank_next;
    logic                      free_vld_reg, free_vld_next;
    logic [IW-1:0]             free_idx_reg, free_idx_next;

    logic [IW-1:0]             slot_reg, slot_next;
    logic [IW-1:0]             limit_reg, limit_next;
    logic                      age_all_reg, age_all_next;
    logic                      insert_reg, insert_next;
    logic                      write_kv_reg, write_kv_next;

    logic                      rsp_valid_reg, rsp_valid_next;
    lkv_pkg::rsp_word_t        rsp_word_reg, rsp_word_next;

    logic [lkv_pkg::KEY_W-1:0] rd_key;
    logic [lkv_pkg::VAL_W-1:0] rd_value;
    logic [IW-1:0]             rd_rank;
    logic [IW-1:0]             ref_rank;
    lkv_pkg::cmp_t             cmp;
    lkv_pkg::ram_we_t          ram_we;
    logic [IW-1:0]             wr_addr;
    logic [IW-1:0]             wr_rank;
    logic                      entry_v;
    logic                      room;

    lkv_entry_ram #(
        .ENTRIES (ENTRIES),
        .IW      (IW)
    ) u_ram (
        .clk      (clk),
        .rd_addr  (cnt_reg[IW-1:0]),
        .wr_addr  (wr_addr),
        .we       (ram_we),
        .wr_key   (key_reg),
        .wr_value (val_reg),
        .wr_rank  (wr_rank),
        .rd_key   (rd_key),
        .rd_value (rd_value),
        .rd_rank  (rd_rank)
    );

    assign ref_rank = (state_reg == lkv_pkg::ST_AGE) ? limit_reg : best_rank_reg;

    lkv_cmp_unit #(
        .IW (IW)
    ) u_cmp (
        .entry_key  (rd_key),
        .ref_key    (key_reg),
        .entry_rank (rd_rank),
        .ref_rank   (ref_rank),
        .cmp        (cmp)
    );

    assign entry_v = valid_reg[rd_idx_reg];

    // A free slot may be filled while used_count is below max(capacity, 1)
    // and below the number of entries.
    assign room = ((EW'(used_reg) < EW'(cap_reg)) ||
                   ((cap_reg == '0) && (used_reg == '0))) &&
                  (EW'(used_reg) < EW'(ENTRIES));

    assign req_stall = (state_reg != lkv_pkg::ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp_word  = rsp_word_reg;

    always_comb
    begin
        state_next      = state_reg;
        cap_next        = cfg_we ? cfg_wdata : cap_reg;
        valid_next      = valid_reg;
        used_next       = used_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        val_next        = val_reg;
        cnt_next        = cnt_reg;
        rd_vld_next     = 1'b0;
        rd_idx_next     = cnt_reg[IW-1:0];
        found_next      = found_reg;
        found_idx_next  = found_idx_reg;
        found_rank_next = found_rank_reg;
        found_val_next  = found_val_reg;
        best_vld_next   = best_vld_reg;
        best_idx_next   = best_idx_reg;
        best_rank_next  = best_rank_reg;
        free_vld_next   = free_vld_reg;
        free_idx_next   = free_idx_reg;
        slot_next       = slot_reg;
        limit_next      = limit_reg;
        age_all_next    = age_all_reg;
        insert_next     = insert_reg;
        write_kv_next   = write_kv_reg;
        rsp_valid_next  = rsp_valid_reg && rsp_stall;
        rsp_word_next   = rsp_word_reg;
        ram_we          = '0;
        wr_addr         = rd_idx_reg;
        wr_rank         = rd_rank + IW'(1);

        case (state_reg)
            lkv_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    op_next       = req_word.opcode;
                    key_next      = req_word.lookup_key;
                    val_next      = req_word.store_value;
                    cnt_next      = '0;
                    found_next    = 1'b0;
                    best_vld_next = 1'b0;
                    free_vld_next = 1'b0;
                    state_next    = lkv_pkg::ST_SCAN;
                end
            end

            lkv_pkg::ST_SCAN:
            begin
                if (cnt_reg != LAST)
                begin
                    rd_vld_next = 1'b1;
                    cnt_next    = cnt_reg + CW'(1);
                end
                else
                begin
                    state_next = lkv_pkg::ST_DECIDE;
                end
                if (rd_vld_reg)
                begin
                    if (entry_v && cmp.key_eq && !found_reg)
                    begin
                        found_next      = 1'b1;
                        found_idx_next  = rd_idx_reg;
                        found_rank_next = rd_rank;
                        found_val_next  = rd_value;
                    end
                    if (entry_v && (!best_vld_reg || cmp.rank_gt))
                    begin
                        best_vld_next  = 1'b1;
                        best_idx_next  = rd_idx_reg;
                        best_rank_next = rd_rank;
                    end
                    if (!entry_v && !free_vld_reg)
                    begin
                        free_vld_next = 1'b1;
                        free_idx_next = rd_idx_reg;
                    end
                end
            end

            lkv_pkg::ST_DECIDE:
            begin
                if (!(rsp_valid_reg && rsp_stall))
                begin
                    rsp_valid_next         = 1'b1;
                    rsp_word_next.hit      = found_reg;
                    rsp_word_next.read_value =
                        (found_reg && (op_reg == lkv_pkg::OP_GET)) ? found_val_reg : '0;
                    write_kv_next = (op_reg == lkv_pkg::OP_PUT);
                    insert_next   = 1'b0;
                    age_all_next  = 1'b0;
                    cnt_next      = '0;
                    state_next    = lkv_pkg::ST_AGE;
                    if (found_reg)
                    begin
                        slot_next  = found_idx_reg;
                        limit_next = found_rank_reg;
                    end
                    else if (op_reg == lkv_pkg::OP_GET)
                    begin
                        state_next = lkv_pkg::ST_IDLE;
                    end
                    else if (room)
                    begin
                        // A fresh slot is older than every entry, so all age.
                        slot_next    = free_idx_reg;
                        age_all_next = 1'b1;
                        insert_next  = 1'b1;
                    end
                    else
                    begin
                        slot_next  = best_idx_reg;
                        limit_next = best_rank_reg;
                    end
                end
            end

            lkv_pkg::ST_AGE:
            begin
                if (cnt_reg != LAST)
                begin
                    rd_vld_next = 1'b1;
                    cnt_next    = cnt_reg + CW'(1);
                end
                else
                begin
                    state_next = lkv_pkg::ST_COMMIT;
                end
                // Read-modify-write trails the read address by one entry.
                if (rd_vld_reg && entry_v && (rd_idx_reg != slot_reg) &&
                    (age_all_reg || cmp.rank_lt))
                begin
                    ram_we.rank = 1'b1;
                end
            end

            lkv_pkg::ST_COMMIT:
            begin
                ram_we.rank = 1'b1;
                ram_we.kv   = write_kv_reg;
                wr_addr     = slot_reg;
                wr_rank     = '0;
                if (insert_reg)
                begin
                    valid_next[slot_reg] = 1'b1;
                    used_next            = used_reg + CW'(1);
                end
                state_next = lkv_pkg::ST_IDLE;
            end

            default:
            begin
                state_next = lkv_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lkv_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= lkv_pkg::CAP_RESET;
            valid_reg     <= '0;
            used_reg      <= '0;
            cnt_reg       <= '0;
            rd_vld_reg    <= 1'b0;
            found_reg     <= 1'b0;
            best_vld_reg  <= 1'b0;
            free_vld_reg  <= 1'b0;
            age_all_reg   <= 1'b0;
            insert_reg    <= 1'b0;
            write_kv_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            cap_reg       <= cap_next;
            valid_reg     <= valid_next;
            used_reg      <= used_next;
            cnt_reg       <= cnt_next;
            rd_vld_reg    <= rd_vld_next;
            found_reg     <= found_next;
            best_vld_reg  <= best_vld_next;
            free_vld_reg  <= free_vld_next;
            age_all_reg   <= age_all_next;
            insert_reg    <= insert_next;
            write_kv_reg  <= write_kv_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        key_reg        <= key_next;
        val_reg        <= val_next;
        rd_idx_reg     <= rd_idx_next;
        found_idx_reg  <= found_idx_next;
        found_rank_reg <= found_rank_next;
        found_val_reg  <= found_val_next;
        best_idx_reg   <= best_idx_next;
        best_rank_reg  <= best_rank_next;
        free_idx_reg   <= free_idx_next;
        slot_reg       <= slot_next;
        limit_reg      <= limit_next;
        rsp_word_reg   <= rsp_word_next;
    end

    // The fill count always matches the number of valid entries.
    `ASSERT_ALWAYS(a_used_matches_valid, clk, rst_n,
        $countones(valid_reg) == used_reg, "used count differs from valid entries")

    // An eviction always has a valid victim.
    `ASSERT_IMPLY(a_victim_found, clk, rst_n,
        (state_reg == lkv_pkg::ST_DECIDE) && !found_reg &&
        (op_reg == lkv_pkg::OP_PUT) && !room,
        best_vld_reg, "eviction without a victim")

    // A fill only goes to an empty slot.
    `ASSERT_IMPLY(a_fill_free_slot, clk, rst_n,
        (state_reg == lkv_pkg::ST_COMMIT) && insert_reg,
        !valid_reg[slot_reg], "fill targets an occupied slot")

endmodule

### sv/lkv_entry_ram.sv
// ----------------------------------------------------------------------------
// lkv_entry_ram
// Key, value and recency-rank memories with one registered read port and
// one write port addressed together.
// ----------------------------------------------------------------------------
module lkv_entry_ram #(
    parameter int ENTRIES = 16,
    parameter int IW      = 4
) (
    input  logic                      clk,
    input  logic [IW-1:0]             rd_addr,
    input  logic [IW-1:0]             wr_addr,
    input  lkv_pkg::ram_we_t          we,
    input  logic [lkv_pkg::KEY_W-1:0] wr_key,
    input  logic [lkv_pkg::VAL_W-1:0] wr_value,
    input  logic [IW-1:0]             wr_rank,
    output logic [lkv_pkg::KEY_W-1:0] rd_key,
    output logic [lkv_pkg::VAL_W-1:0] rd_value,
    output logic [IW-1:0]             rd_rank
);

    logic [lkv_pkg::KEY_W-1:0] key_mem   [ENTRIES];
    logic [lkv_pkg::VAL_W-1:0] value_mem [ENTRIES];
    logic [IW-1:0]             rank_mem  [ENTRIES];

    always_ff @(posedge clk)
    begin
        if (we.kv)
        begin
            key_mem[wr_addr]   <= wr_key;
            value_mem[wr_addr] <= wr_value;
        end
        if (we.rank)
        begin
            rank_mem[wr_addr] <= wr_rank;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_key   <= key_mem[rd_addr];
        rd_value <= value_mem[rd_addr];
        rd_rank  <= rank_mem[rd_addr];
    end

endmodule

### sv/lkv_cmp_unit.sv
// ----------------------------------------------------------------------------
// lkv_cmp_unit
// Shared compare unit: key equality and rank ordering for the entry
// that is being visited.
// ----------------------------------------------------------------------------
module lkv_cmp_unit #(
    parameter int IW = 4
) (
    input  logic [lkv_pkg::KEY_W-1:0] entry_key,
    input  logic [lkv_pkg::KEY_W-1:0] ref_key,
    input  logic [IW-1:0]             entry_rank,
    input  logic [IW-1:0]             ref_rank,
    output lkv_pkg::cmp_t             cmp
);

    always_comb
    begin
        cmp.key_eq  = (entry_key == ref_key);
        cmp.rank_gt = (entry_rank > ref_rank);
        cmp.rank_lt = (entry_rank < ref_rank);
    end

endmodule

### tb/sv/lru_key_value_cache_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_key_value_cache_tb
// Self-checking bench for the LRU key-value cache. A directed table covers
// empty-cache misses, key and value extremes, put updates and capacity edge
// settings. Random phases follow, one per capacity setting, and draw keys
// mostly from a small pool so that hits, updates and evictions are frequent.
// A behavioral LRU model predicts every response word not fixed in the table.
// ----------------------------------------------------------------------------
module lru_key_value_cache_tb;

    localparam int ENTRIES    = 16;
    localparam int IDLE_PCT   = 26;
    localparam int PHASE_LEN  = 170;
    // A hit or a put keeps aging ranks after its response, so let that pass finish.
    localparam int SETTLE     = 2 * ENTRIES + 8;
    localparam int CYCLE_LIMIT = 600000;

    typedef enum bit {
        ROW_REQ,
        ROW_CFG
    } row_kind_t;

    typedef struct {
        row_kind_t                 kind;
        logic [lkv_pkg::CAP_W-1:0] cap;
        lkv_pkg::req_word_t        word;
        bit                        typed;
        lkv_pkg::rsp_word_t        want;
    } stim_row_t;

    logic                      clk;
    logic                      rst_n;
    logic                      req_valid;
    logic                      req_stall;
    lkv_pkg::req_word_t        req_word;
    logic                      rsp_valid;
    logic                      rsp_stall;
    lkv_pkg::rsp_word_t        rsp_word;
    logic                      cfg_we;
    logic [lkv_pkg::CAP_W-1:0] cfg_wdata;

    // Shadow copy of the cache contents and recency order.
    bit                        shadow_valid [ENTRIES];
    logic [lkv_pkg::KEY_W-1:0] shadow_key   [ENTRIES];
    logic [lkv_pkg::VAL_W-1:0] shadow_val   [ENTRIES];
    int                        shadow_rank  [ENTRIES];
    int                        shadow_used;
    logic [lkv_pkg::CAP_W-1:0] cache_cap;

    lkv_pkg::rsp_word_t        pending_rsp [$];
    stim_row_t                 plan [$];
    int                        fail_count;
    int                        cycle_count;
    bit                        quiet;

    lru_key_value_cache #(
        .ENTRIES (ENTRIES)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_word  (req_word),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_word  (rsp_word),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic int eff_capacity(logic [lkv_pkg::CAP_W-1:0] c);
        if (c == 0)
            return 1;
        if (c > ENTRIES)
            return ENTRIES;
        return int'(c);
    endfunction

    // Entry s becomes the most recent; valid entries newer than it age by one.
    function automatic void promote(int s);
        int bound;
        bound = shadow_valid[s] ? shadow_rank[s] : ENTRIES + 1;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (i != s && shadow_valid[i] && shadow_rank[i] < bound)
                shadow_rank[i]++;
        end
        shadow_rank[s] = 0;
    endfunction

    function automatic lkv_pkg::rsp_word_t lru_access(lkv_pkg::req_word_t w);
        lkv_pkg::rsp_word_t r;
        int                 found;
        int                 slot;
        r     = '0;
        found = -1;
        slot  = -1;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (found < 0 && shadow_valid[i] && shadow_key[i] == w.lookup_key)
                found = i;
        end
        if (found >= 0)
        begin
            r.hit = 1'b1;
            if (w.opcode == lkv_pkg::OP_GET)
                r.read_value = shadow_val[found];
            else
                shadow_val[found] = w.store_value;
            promote(found);
            return r;
        end
        if (w.opcode == lkv_pkg::OP_GET)
            return r;
        if (shadow_used < eff_capacity(cache_cap))
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (slot < 0 && !shadow_valid[i])
                    slot = i;
            end
        end
        if (slot >= 0)
        begin
            promote(slot);
            shadow_valid[slot] = 1'b1;
            shadow_used++;
        end
        else
        begin
            // Full, or capacity lowered below the fill level: replace the oldest.
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (shadow_valid[i] && (slot < 0 || shadow_rank[i] > shadow_rank[slot]))
                    slot = i;
            end
            promote(slot);
        end
        shadow_key[slot] = w.lookup_key;
        shadow_val[slot] = w.store_value;
        return r;
    endfunction

    task automatic send_word(input lkv_pkg::req_word_t w, input bit typed,
                             input lkv_pkg::rsp_word_t want);
        lkv_pkg::rsp_word_t got;
        if (!quiet && $urandom_range(99) < IDLE_PCT)
        begin
            req_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < IDLE_PCT);
        end
        req_valid <= 1'b1;
        req_word  <= w;
        do
            @(posedge clk);
        while (req_stall);
        got = lru_access(w);
        pending_rsp.push_back(typed ? want : got);
    endtask

    task automatic set_capacity(input logic [lkv_pkg::CAP_W-1:0] c);
        req_valid <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= c;
        @(posedge clk);
        cfg_we    <= 1'b0;
        cache_cap = c;
    endtask

    always @(posedge clk)
    begin
        rsp_stall <= rst_n && !quiet && ($urandom_range(99) < IDLE_PCT);
    end

    always @(posedge clk)
    begin : rsp_check
        lkv_pkg::rsp_word_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_rsp.size() == 0)
            begin
                $error("response word with none expected: hit %0d read_value %08h",
                       rsp_word.hit, rsp_word.read_value);
                fail_count++;
            end
            else
            begin
                want = pending_rsp.pop_front();
                if (rsp_word.hit !== want.hit)
                begin
                    $error("hit: expected %0d, actual %0d", want.hit, rsp_word.hit);
                    fail_count++;
                end
                if (rsp_word.read_value !== want.read_value)
                begin
                    $error("read_value: expected %08h, actual %08h",
                           want.read_value, rsp_word.read_value);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("lru_key_value_cache_tb failed");
            $finish;
        end
    end

    initial
    begin : stimulus
        logic [lkv_pkg::CAP_W-1:0] phase_caps [9];
        logic [lkv_pkg::KEY_W-1:0] key_pool [ENTRIES + 4];
        int                        pool_size;
        lkv_pkg::req_word_t        w;

        rst_n       <= 1'b0;
        req_valid   <= 1'b0;
        req_word    <= '0;
        cfg_we      <= 1'b0;
        cfg_wdata   <= '0;
        fail_count  = 0;
        cycle_count = 0;
        quiet       = 1'b0;
        cache_cap   = lkv_pkg::CAP_RESET;
        shadow_used = 0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            shadow_valid[i] = 1'b0;
            shadow_key[i]   = '0;
            shadow_val[i]   = '0;
            shadow_rank[i]  = 0;
        end

        // Empty cache, key and value extremes, update on hit, gets ignore the value.
        plan.push_back('{ROW_REQ, 5'd0, '{lkv_pkg::OP_GET, 16'h0000, 32'h0}, 1'b1,
                         '{1'b0, 32'h0}});
        plan.push_back('{ROW_REQ, 5'd0, '{lkv_pkg::OP_GET, 16'hFFFF, 32'hFFFFFFFF}, 1'b1,
                         '{1'b0, 32'h0}});
        plan.push_back('{ROW_REQ, 5'd0, '{lkv_pkg::OP_PUT, 16'h0000, 32'hFFFFFFFF}, 1'b1,
                         '{1'b0, 32'h0}});
        plan.push_back('{ROW_REQ, 5'd0, '{lkv_pkg::OP_PUT, 16'hFFFF, 32'h00000000}, 1'b1,
                         '{1'b0, 32'h0}});
        plan.push_back('{ROW_REQ, 5'd0, '{lkv_pkg::OP_GET, 16'h0000, 32'h0}, 1'b1,
                         '{1'b1, 32'hFFFFFFFF}});
        plan.push_back('{ROW_REQ, 5'd0, '{lkv_pkg::OP_GET, 16'hFFFF, 32'h0}, 1'b1,
                         '{1'b1, 32'h0}});
        plan.push_back('{ROW_REQ, 5'd0, '{lkv_pkg::OP_PUT, 16'hFFFF, 32'hA5A5A5A5}, 1'b1,
                         '{1'b1, 32'h0}});
        plan.push_back('{ROW_REQ, 5'd0, '{lkv_pkg::OP_GET, 16'hFFFF, 32'h0}, 1'b1,
                         '{1'b1, 32'hA5A5A5A5}});
        plan.push_back('{ROW_REQ, 5'd0, '{lkv_pkg::OP_GET, 16'h0000, 32'h0}, 1'b0,
                         '{1'b0, 32'h0}});
        // Capacity zero acts as one, and sits below the current fill level.
        plan.push_back('{ROW_CFG, 5'd0, '{lkv_pkg::OP_GET, 16'h0, 32'h0}, 1'b0,
                         '{1'b0, 32'h0}});
        plan.push_back('{ROW_REQ, 5'd0, '{lkv_pkg::OP_PUT, 16'h1234, 32'h5A5A5A5A}, 1'b1,
                         '{1'b0, 32'h0}});
        plan.push_back('{ROW_REQ, 5'd0, '{lkv_pkg::OP_GET, 16'hFFFF, 32'h0}, 1'b0,
                         '{1'b0, 32'h0}});
        plan.push_back('{ROW_REQ, 5'd0, '{lkv_pkg::OP_GET, 16'h0000, 32'h0}, 1'b0,
                         '{1'b0, 32'h0}});
        plan.push_back('{ROW_REQ, 5'd0, '{lkv_pkg::OP_GET, 16'h1234, 32'h0}, 1'b0,
                         '{1'b0, 32'h0}});
        // Capacity above the entry count acts as the entry count.
        plan.push_back('{ROW_CFG, 5'd31, '{lkv_pkg::OP_GET, 16'h0, 32'h0}, 1'b0,
                         '{1'b0, 32'h0}});
        plan.push_back('{ROW_REQ, 5'd0, '{lkv_pkg::OP_PUT, 16'h0001, 32'h00000001}, 1'b0,
                         '{1'b0, 32'h0}});
        plan.push_back('{ROW_REQ, 5'd0, '{lkv_pkg::OP_PUT, 16'h8000, 32'h80000000}, 1'b0,
                         '{1'b0, 32'h0}});
        plan.push_back('{ROW_REQ, 5'd0, '{lkv_pkg::OP_GET, 16'h1234, 32'h0}, 1'b0,
                         '{1'b0, 32'h0}});
        plan.push_back('{ROW_REQ, 5'd0, '{lkv_pkg::OP_GET, 16'h8000, 32'h0}, 1'b0,
                         '{1'b0, 32'h0}});
        plan.push_back('{ROW_CFG, 5'd1, '{lkv_pkg::OP_GET, 16'h0, 32'h0}, 1'b0,
                         '{1'b0, 32'h0}});
        plan.push_back('{ROW_REQ, 5'd0, '{lkv_pkg::OP_PUT, 16'h4321, 32'hDEADBEEF}, 1'b0,
                         '{1'b0, 32'h0}});
        plan.push_back('{ROW_REQ, 5'd0, '{lkv_pkg::OP_GET, 16'h4321, 32'h0}, 1'b0,
                         '{1'b0, 32'h0}});
        plan.push_back('{ROW_REQ, 5'd0, '{lkv_pkg::OP_GET, 16'h1234, 32'h0}, 1'b0,
                         '{1'b0, 32'h0}});

        phase_caps = '{5'd16, 5'd3, 5'd0, 5'd31, 5'd8, 5'd1, 5'd12, 5'd2, 5'd16};

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_CFG)
                set_capacity(plan[i].cap);
            else
                send_word(plan[i].word, plan[i].typed, plan[i].want);
        end

        for (int p = 0; p < 9; p++)
        begin
            set_capacity(phase_caps[p]);
            quiet = (p == 3);
            // A pool a little larger than the capacity gives hits and evictions.
            pool_size = eff_capacity(phase_caps[p]) + 4;
            for (int k = 0; k < pool_size; k++)
                key_pool[k] = lkv_pkg::KEY_W'($urandom);
            for (int n = 0; n < PHASE_LEN; n++)
            begin
                w.opcode      = 1'($urandom_range(1));
                w.store_value = $urandom;
                if ($urandom_range(99) < 85)
                    w.lookup_key = key_pool[$urandom_range(pool_size - 1)];
                else
                    w.lookup_key = lkv_pkg::KEY_W'($urandom);
                send_word(w, 1'b0, '0);
            end
        end
        quiet = 1'b0;
        req_valid <= 1'b0;

        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (fail_count == 0)
            $display("lru_key_value_cache_tb passed");
        else
            $display("lru_key_value_cache_tb failed");
        $finish;
    end

endmodule
